// File: rtl/bounded_deque_with_remove_core_assert.svh
// Assertion macros used by the deque datapath.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define BDQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Types and constants shared by the deque controller, datapath and top level.
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY = 64;
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REMOVED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] popped_value;
        logic [COUNT_W-1:0]        entry_count;
    } t_out_word;

    // Commands from the controller to the datapath for one cycle.
    typedef struct packed {
        logic    accept;
        logic    place;
        logic    link;
        logic    unlink;
        logic    advance;
        logic    take_pop;
        logic    st_wr;
        t_status st;
        logic    load_out;
    } t_dp_ctl;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic walk_end;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/bdq_ctrl.sv
// Sequencing state machine of the deque: one command at a time.
`default_nettype none

module bdq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bdq_pkg::CMD_W-1:0]  i_cmd,
    input  bdq_pkg::t_dp_sts           i_sts,
    output bdq_pkg::t_dp_ctl           o_ctl,
    output logic                       o_in_stall
);
    import bdq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PLACE = 6'b000010,
        S_LINK  = 6'b000100,
        S_POP   = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    o_ctl.st_wr  = 1'b1;
                    o_ctl.st     = ST_OK;
                    n_state      = S_DONE;
                    unique case (i_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (i_sts.full) begin
                                o_ctl.st = ST_FULL;
                            end else begin
                                n_state = S_PLACE;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (i_sts.empty) begin
                                o_ctl.st = ST_EMPTY;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!i_sts.empty) begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PLACE: begin
                o_ctl.place = 1'b1;
                n_state     = S_LINK;
            end
            S_LINK: begin
                o_ctl.link = 1'b1;
                n_state    = S_DONE;
            end
            S_POP: begin
                o_ctl.unlink   = 1'b1;
                o_ctl.take_pop = 1'b1;
                n_state        = S_DONE;
            end
            S_WALK: begin
                if (i_sts.match) begin
                    o_ctl.unlink = 1'b1;
                    o_ctl.st_wr  = 1'b1;
                    o_ctl.st     = ST_REMOVED;
                    n_state      = S_DONE;
                end else if (i_sts.walk_end) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.advance = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/bdq_dpath.sv
// Deque datapath: entry, link and free-slot memories, list pointers and result register.
`default_nettype none
`include "bounded_deque_with_remove_core_assert.svh"

module bdq_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdq_pkg::t_dp_ctl   i_ctl,
    input  bdq_pkg::t_in_word  i_in_word,
    input  logic               i_out_stall,
    output bdq_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output bdq_pkg::t_out_word o_out_word
);
    import bdq_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    // Storage. Slots above the high-water mark have never been used.
    logic [VALUE_W-1:0] r_vals [CAPACITY];
    logic [LW-1:0]      r_next [CAPACITY];
    logic [LW-1:0]      r_prev [CAPACITY];
    logic [AW-1:0]      r_fstk [CAPACITY];

    logic [LW-1:0] r_head, r_tail, r_count, r_hw, r_fsp;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [VALUE_W-1:0] r_val;
    logic [LW-1:0]             r_cur, r_steps, r_slot;
    logic signed [VALUE_W-1:0] r_popped;
    t_status                   r_status;
    logic                      r_out_valid;
    t_out_word                 r_out_word;

    logic [VALUE_W-1:0] r_rd_val;
    logic [LW-1:0]      r_rd_nxt, r_rd_prv;
    logic [AW-1:0]      r_rd_fs;

    logic          front;
    logic [LW-1:0] acc_idx, place_slot, fsp_dec;
    logic [AW-1:0] rd_addr, fs_ra;
    logic          rd_en;
    logic [LW:0]   steps_inc;

    logic          vals_we, next_we, prev_we, fstk_we;
    logic [AW-1:0] vals_wa, next_wa, prev_wa, fstk_wa;
    logic [LW-1:0] next_wd, prev_wd;
    logic [AW-1:0] fstk_wd;

    always_comb begin
        front      = (r_cmd == CMD_PUSH_FRONT);
        acc_idx    = (i_in_word.cmd == CMD_POP_BACK) ? r_tail : r_head;
        place_slot = (r_fsp != '0) ? LW'(r_rd_fs) : r_hw;
        fsp_dec    = r_fsp - LW'(1);
        fs_ra      = fsp_dec[AW-1:0];
        rd_en      = i_ctl.accept | i_ctl.advance;
        rd_addr    = i_ctl.advance ? r_rd_nxt[AW-1:0] : acc_idx[AW-1:0];
        steps_inc  = {1'b0, r_steps} + (LW+1)'(1);
    end

    // Write ports: each memory takes at most one write per cycle.
    always_comb begin
        vals_we = i_ctl.place;
        vals_wa = place_slot[AW-1:0];

        next_we = 1'b0;
        next_wa = place_slot[AW-1:0];
        next_wd = front ? r_head : NIL;
        prev_we = 1'b0;
        prev_wa = place_slot[AW-1:0];
        prev_wd = front ? NIL : r_tail;

        if (i_ctl.place) begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end else if (i_ctl.link) begin
            if (front) begin
                prev_we = (r_head != NIL);
                prev_wa = r_head[AW-1:0];
                prev_wd = r_slot;
            end else begin
                next_we = (r_tail != NIL);
                next_wa = r_tail[AW-1:0];
                next_wd = r_slot;
            end
        end else if (i_ctl.unlink) begin
            next_we = (r_rd_prv != NIL);
            next_wa = r_rd_prv[AW-1:0];
            next_wd = r_rd_nxt;
            prev_we = (r_rd_nxt != NIL);
            prev_wa = r_rd_nxt[AW-1:0];
            prev_wd = r_rd_prv;
        end

        fstk_we = i_ctl.unlink;
        fstk_wa = r_fsp[AW-1:0];
        fstk_wd = r_cur[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (vals_we) r_vals[vals_wa] <= r_val;
        if (next_we) r_next[next_wa] <= next_wd;
        if (prev_we) r_prev[prev_wa] <= prev_wd;
        if (fstk_we) r_fstk[fstk_wa] <= fstk_wd;
        if (rd_en) begin
            r_rd_val <= r_vals[rd_addr];
            r_rd_nxt <= r_next[rd_addr];
            r_rd_prv <= r_prev[rd_addr];
            r_rd_fs  <= r_fstk[fs_ra];
        end
    end

    // List pointers and allocation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_hw        <= '0;
            r_fsp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.place) begin
                if (r_fsp != '0) begin
                    r_fsp <= fsp_dec;
                end else begin
                    r_hw <= r_hw + LW'(1);
                end
            end else if (i_ctl.link) begin
                r_count <= r_count + LW'(1);
                if (front) begin
                    r_head <= r_slot;
                    if (r_head == NIL) r_tail <= r_slot;
                end else begin
                    r_tail <= r_slot;
                    if (r_tail == NIL) r_head <= r_slot;
                end
            end else if (i_ctl.unlink) begin
                if (r_rd_prv == NIL) r_head <= r_rd_nxt;
                if (r_rd_nxt == NIL) r_tail <= r_rd_prv;
                r_fsp   <= r_fsp + LW'(1);
                r_count <= r_count - LW'(1);
            end

            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-command working registers and the result word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd    <= i_in_word.cmd;
            r_val    <= i_in_word.item_value;
            r_cur    <= acc_idx;
            r_steps  <= '0;
            r_popped <= '0;
        end
        if (i_ctl.advance) begin
            r_cur   <= r_rd_nxt;
            r_steps <= steps_inc[LW-1:0];
        end
        if (i_ctl.place) r_slot <= place_slot;
        if (i_ctl.st_wr) r_status <= i_ctl.st;
        if (i_ctl.take_pop) r_popped <= r_rd_val;
        if (i_ctl.load_out) begin
            r_out_word.status       <= r_status;
            r_out_word.popped_value <= r_popped;
            r_out_word.entry_count  <= COUNT_W'(r_count);
        end
    end

    always_comb begin
        o_sts.full     = (r_count == NIL);
        o_sts.empty    = (r_count == '0);
        o_sts.match    = (r_rd_val == r_val);
        o_sts.walk_end = (steps_inc >= {1'b0, r_count}) || (r_rd_nxt == NIL);
        o_sts.out_busy = r_out_valid & i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `BDQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= NIL, "count above capacity")
    `BDQ_ASSERT_ALWAYS(a_head_nil, i_clk, i_rst_n, (r_head == NIL) == (r_count == '0), "head and count disagree")
    `BDQ_ASSERT_ALWAYS(a_tail_nil, i_clk, i_rst_n, (r_tail == NIL) == (r_count == '0), "tail and count disagree")
    `BDQ_ASSERT_NEXT(a_link_nonempty, i_clk, i_rst_n, i_ctl.link, (r_head != NIL) && (r_tail != NIL), "push left list empty")
    `BDQ_ASSERT_SAME(a_unlink_held, i_clk, i_rst_n, i_ctl.unlink, r_count != '0, "unlink on empty list")

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_remove_core.sv
// Top level of the bounded deque with remove: controller plus datapath.
// Path from accept to result valid: a push goes through PLACE, LINK and DONE, a pop through
// POP and DONE; a full push, empty pop, empty remove or spare code goes straight to DONE; a
// remove walks one entry per cycle through the single read port of the entry and link
// memories to a match or the end; DONE waits out output stalls, then IDLE takes a new word.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
`default_nettype none

module bounded_deque_with_remove_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdq_pkg::t_out_word o_out_word
);
    import bdq_pkg::*;

    // The controller walks each word through its steps; the datapath holds
    // the list in three memories (values, next links, previous links) and a
    // stack of released slots. A push takes a released slot when one exists,
    // otherwise the next never-used slot above the high-water mark, so the
    // memories need no initialization: only slots written by a push are used.
    t_dp_ctl ctl;
    t_dp_sts sts;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_word.cmd),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    // Pops and removes unlink an entry from the registered read of its
    // links; a remove compares one entry per cycle while it walks.
    bdq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
